[rtl/core/particle_sensor_frame_parser_defines.svh]
// Assertion macros for the particle sensor frame parser.
// Included by the top level; the macros expect aclk and aresetn in scope.
`ifndef PARTICLE_SENSOR_FRAME_PARSER_DEFINES_SVH
`define PARTICLE_SENSOR_FRAME_PARSER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSFP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PSFP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/psfp_pkg.sv]
// Shared types and constants of the particle sensor frame parser.
// Used by the word memory, the control unit and the top level.
`timescale 1ns / 1ps

package psfp_pkg;

    localparam int BYTE_W       = 8;
    localparam int WORD_W       = 16;
    localparam int FRAME_BYTES  = 32;
    localparam int SUMMED_BYTES = 30;
    localparam int DATA_WORDS   = 14;
    localparam int POS_W        = $clog2(FRAME_BYTES);
    localparam int IDX_W        = $clog2(DATA_WORDS);

    localparam logic [BYTE_W-1:0] SYNC_BYTE_RESET = 8'h42;
    localparam logic [POS_W-1:0]  LAST_POS        = POS_W'(FRAME_BYTES - 1);
    localparam logic [POS_W-1:0]  SUM_END_POS     = POS_W'(SUMMED_BYTES);
    localparam logic [IDX_W-1:0]  LAST_IDX        = IDX_W'(DATA_WORDS - 1);

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_RECV,
        ST_READ,
        ST_SHOW,
        ST_ERR
    } psfp_state_t;

    // Access request from the control unit to the word memory.
    typedef struct packed {
        logic              wr_en;
        logic [IDX_W-1:0]  wr_addr;
        logic [WORD_W-1:0] wr_data;
        logic              rd_en;
        logic [IDX_W-1:0]  rd_addr;
    } psfp_ram_req_t;

endpackage

[rtl/core/particle_sensor_frame_parser.sv]
// Particle sensor frame parser. Takes one byte per beat while receiving.
// After the final byte of a 32-byte frame the input stalls while results go
// out: one error beat on a checksum mismatch, or fourteen word beats, each
// a word memory read and then the beat on the output, held by any
// downstream stall. The word memory needs no clearing after reset.
// Depends on psfp_pkg, psfp_ctrl, psfp_word_ram and the assertion macros.
`timescale 1ns / 1ps
`include "particle_sensor_frame_parser_defines.svh"

module particle_sensor_frame_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,    // sync_byte
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,      // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,      // [3:0] word_index, [19:4] word_value, [23:20] zero
    output logic        m_tuser,      // [0] frame_error
    output logic        m_tlast       // last
);

    psfp_pkg::psfp_ram_req_t          ram_req;
    logic [psfp_pkg::WORD_W-1:0]      ram_rd_data;
    logic [psfp_pkg::IDX_W-1:0]       word_index;
    logic [psfp_pkg::WORD_W-1:0]      word_value;

    // Control unit.
    psfp_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .rx_byte     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .frame_error (m_tuser),
        .word_index  (word_index),
        .word_value  (word_value),
        .last        (m_tlast),
        .ram_req     (ram_req),
        .ram_rd_data (ram_rd_data)
    );

    // Word store.
    psfp_word_ram u_word_ram (
        .aclk    (aclk),
        .req     (ram_req),
        .rd_data (ram_rd_data)
    );

    // Pack the result beat.
    assign m_tdata = {4'b0000, word_value, word_index};

    // An error result stands alone.
    `PSFP_ASSERT_SAME(a_err_is_last, m_tvalid && m_tuser, m_tlast, "error beat without last")
    // No byte is taken while results are pending.
    `PSFP_ASSERT_SAME(a_no_rx_during_emit, m_tvalid, !s_tready, "input open during emit")
    // The word memory is written only by an accepted byte.
    `PSFP_ASSERT_SAME(a_write_on_byte, ram_req.wr_en, s_tvalid && s_tready,
                      "word write without byte")
    // After a non-final word beat is taken, the next word is read first.
    `PSFP_ASSERT_NEXT(a_read_gap, m_tvalid && m_tready && !m_tlast, !m_tvalid,
                      "word beat without memory read")

endmodule

[rtl/core/psfp_word_ram.sv]
// Word store of the frame parser: one write port, one registered read port.
// Depends on psfp_pkg for widths, depth and the request struct.
`timescale 1ns / 1ps

module psfp_word_ram (
    input  logic                             aclk,
    input  psfp_pkg::psfp_ram_req_t          req,
    output logic [psfp_pkg::WORD_W-1:0]      rd_data
);

    logic [psfp_pkg::WORD_W-1:0] word_mem [psfp_pkg::DATA_WORDS];
    logic [psfp_pkg::WORD_W-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            word_mem[req.wr_addr] <= req.wr_data;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_data_reg <= word_mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/psfp_ctrl.sv]
// Control unit of the frame parser: sync hunt, checksum, word assembly
// and the emit sequencer. Depends on psfp_pkg.
`timescale 1ns / 1ps

module psfp_ctrl (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [psfp_pkg::BYTE_W-1:0]      cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [psfp_pkg::BYTE_W-1:0]      rx_byte,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic                             frame_error,
    output logic [psfp_pkg::IDX_W-1:0]       word_index,
    output logic [psfp_pkg::WORD_W-1:0]      word_value,
    output logic                             last,
    output psfp_pkg::psfp_ram_req_t          ram_req,
    input  logic [psfp_pkg::WORD_W-1:0]      ram_rd_data
);

    psfp_pkg::psfp_state_t state_reg, state_next;

    logic [psfp_pkg::BYTE_W-1:0] sync_reg, sync_next;
    logic [psfp_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic [psfp_pkg::WORD_W-1:0] sum_reg, sum_next;
    logic [psfp_pkg::BYTE_W-1:0] hold_reg, hold_next;
    logic [psfp_pkg::IDX_W-1:0]  idx_reg, idx_next;

    logic                        byte_acc;
    logic                        frame_end;
    logic [psfp_pkg::WORD_W-1:0] word_in;

    assign byte_acc  = s_tvalid && s_tready;
    assign frame_end = byte_acc && (pos_reg == psfp_pkg::LAST_POS);
    assign word_in   = {hold_reg, rx_byte};

    // Next state of the sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            psfp_pkg::ST_RECV: begin
                if (frame_end) begin
                    state_next = (word_in == sum_reg) ? psfp_pkg::ST_READ : psfp_pkg::ST_ERR;
                end
            end
            psfp_pkg::ST_READ: begin
                state_next = psfp_pkg::ST_SHOW;
            end
            psfp_pkg::ST_SHOW: begin
                if (m_tready) begin
                    state_next = (idx_reg == psfp_pkg::LAST_IDX) ?
                                 psfp_pkg::ST_RECV : psfp_pkg::ST_READ;
                end
            end
            psfp_pkg::ST_ERR: begin
                if (m_tready) begin
                    state_next = psfp_pkg::ST_RECV;
                end
            end
            default: begin
                state_next = psfp_pkg::ST_RECV;
            end
        endcase
    end

    // Handshake, result payload and memory requests.
    always_comb begin
        s_tready    = 1'b0;
        m_tvalid    = 1'b0;
        frame_error = 1'b0;
        word_index  = '0;
        word_value  = '0;
        last        = 1'b0;
        ram_req     = '0;
        case (state_reg)
            psfp_pkg::ST_RECV: begin
                s_tready = 1'b1;
                // Odd positions from 3 on complete a data word; the last one
                // completes the checksum, which is not stored.
                ram_req.wr_en   = byte_acc && pos_reg[0] && (pos_reg >= 3)
                                  && (pos_reg != psfp_pkg::LAST_POS);
                ram_req.wr_addr = pos_reg[psfp_pkg::POS_W-1:1] - 1'b1;
                ram_req.wr_data = word_in;
            end
            psfp_pkg::ST_READ: begin
                ram_req.rd_en   = 1'b1;
                ram_req.rd_addr = idx_reg;
            end
            psfp_pkg::ST_SHOW: begin
                m_tvalid   = 1'b1;
                word_index = idx_reg;
                word_value = ram_rd_data;
                last       = (idx_reg == psfp_pkg::LAST_IDX);
            end
            psfp_pkg::ST_ERR: begin
                m_tvalid    = 1'b1;
                frame_error = 1'b1;
                last        = 1'b1;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Frame tracking: sync byte, position, running sum, held high byte, emit index.
    always_comb begin
        sync_next = cfg_we ? cfg_wdata : sync_reg;
        pos_next  = pos_reg;
        sum_next  = sum_reg;
        hold_next = hold_reg;
        idx_next  = idx_reg;
        if (byte_acc) begin
            if (pos_reg == '0) begin
                if (rx_byte == sync_reg) begin
                    sum_next = psfp_pkg::WORD_W'(rx_byte);
                    pos_next = psfp_pkg::POS_W'(1);
                end
            end else begin
                if (pos_reg < psfp_pkg::SUM_END_POS) begin
                    sum_next = sum_reg + psfp_pkg::WORD_W'(rx_byte);
                end
                if ((pos_reg >= 2) && !pos_reg[0]) begin
                    hold_next = rx_byte;
                end
                // Wraps to zero after the last byte, back to hunting.
                pos_next = pos_reg + 1'b1;
            end
        end
        if (frame_end) begin
            idx_next = '0;
        end else if ((state_reg == psfp_pkg::ST_SHOW) && m_tready) begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= psfp_pkg::ST_RECV;
            sync_reg  <= psfp_pkg::SYNC_BYTE_RESET;
            pos_reg   <= '0;
            sum_reg   <= '0;
            hold_reg  <= '0;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            sync_reg  <= sync_next;
            pos_reg   <= pos_next;
            sum_reg   <= sum_next;
            hold_reg  <= hold_next;
            idx_reg   <= idx_next;
        end
    end

endmodule
